FILE: design/ftins_pkg.sv
// Shared types for the Fibonacci tableau insert unit.
// Used by ftins_ctrl, ftins_datapath and the top level. No dependencies.
`default_nettype none

package ftins_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RA_COL    = 2'd0,
    RA_CNT    = 2'd1,
    RA_CNT_M1 = 2'd2,
    RA_START  = 2'd3
  } rd_addr_e;

  typedef enum logic [1:0] {
    WD_SECOND = 2'd0,
    WD_FILL   = 2'd1,
    WD_SHIFT  = 2'd2,
    WD_NEW    = 2'd3
  } wr_data_e;

  typedef struct packed {
    logic [7:0] vt;
    logic [7:0] vs;
    logic [7:0] kt;
    logic [7:0] ks;
  } column_t;

  typedef struct packed {
    logic     capture;
    logic     clear_used;
    logic     inc_used;
    logic     rd_en;
    rd_addr_e rd_addr;
    logic     wr_en;
    wr_data_e wr_data;
    logic     walk_step;
    logic     set_fill;
    logic     set_insert;
    logic     set_append;
    logic     set_ovf;
    logic     p2_init;
    logic     p2_step;
    logic     sh_init;
    logic     sh_step;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic past_end;
    logic val_lt_top;
    logic second_zero;
    logic full_ovf;
    logic cnt_ge_col;
    logic cnt_eq_col;
    logic kind_fill;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: design/fibonacci_tableau_insert_unit.sv
// Top level of the Fibonacci tableau insert unit.
// Instantiates ftins_ctrl and ftins_datapath; depends on ftins_pkg.
//
// Takes one transaction at a time and returns exactly one result for it.
// A clear or an unused op goes from dispatch to the result state, a read also passes a read state.
// An insertion reads and compares each column it walks through, then reads and rewrites
// each column whose second value is rewritten, and reads and writes each column shifted
// right when a new column opens; all of it is paced by the single-port column memory.
// The result sits in an output register, so the next transaction is accepted
// while the previous result still waits to be taken.
`default_nettype none

module fibonacci_tableau_insert_unit #(
  parameter int MAX_COLUMNS = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] key_i,
  input  wire logic [7:0] element_i,
  input  wire logic [5:0] start_column_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [6:0]      column_count_o,
  output logic            overflow_o,
  output logic [5:0]      settled_column_o,
  output logic [7:0]      read_top_o,
  output logic [7:0]      read_second_o,
  output logic [7:0]      read_key_top_o,
  output logic [7:0]      read_key_second_o
);

  ftins_pkg::cmd_t    cmd;
  ftins_pkg::status_t sts;

  ftins_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftins_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .op_i              (op_i),
    .key_i             (key_i),
    .element_i         (element_i),
    .start_column_i    (start_column_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .column_count_o    (column_count_o),
    .overflow_o        (overflow_o),
    .settled_column_o  (settled_column_o),
    .read_top_o        (read_top_o),
    .read_second_o     (read_second_o),
    .read_key_top_o    (read_key_top_o),
    .read_key_second_o (read_key_second_o)
  );

endmodule

`default_nettype wire

FILE: design/ftins_ctrl.sv
// Sequencer for the Fibonacci tableau insert unit.
// Depends on ftins_pkg; drives ftins_datapath through cmd_t, reads status_t.
`default_nettype none

module ftins_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ftins_pkg::status_t sts_i,
  output ftins_pkg::cmd_t       cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_DISPATCH = 12'b000000000010,
    ST_WALK_RD  = 12'b000000000100,
    ST_WALK_CMP = 12'b000000001000,
    ST_DECIDE   = 12'b000000010000,
    ST_P2_RD    = 12'b000000100000,
    ST_P2_WR    = 12'b000001000000,
    ST_FILL_WR  = 12'b000010000000,
    ST_SH_RD    = 12'b000100000000,
    ST_SH_WR    = 12'b001000000000,
    ST_READ     = 12'b010000000000,
    ST_RESULT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.op)
          ftins_pkg::OP_INSERT: state_d = ST_WALK_RD;
          ftins_pkg::OP_READ: begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = ftins_pkg::RA_START;
            state_d = ST_READ;
          end
          ftins_pkg::OP_CLEAR: begin
            cmd_o.clear_used = 1'b1;
            state_d = ST_RESULT;
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_WALK_RD: begin
        if (sts_i.past_end) begin
          cmd_o.set_append = 1'b1;
          state_d = ST_DECIDE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ftins_pkg::RA_COL;
          state_d = ST_WALK_CMP;
        end
      end
      ST_WALK_CMP: begin
        priority if (sts_i.val_lt_top && sts_i.second_zero) begin
          cmd_o.set_fill = 1'b1;
          state_d = ST_DECIDE;
        end else if (sts_i.val_lt_top) begin
          cmd_o.walk_step = 1'b1;
          state_d = ST_WALK_RD;
        end else begin
          cmd_o.set_insert = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.full_ovf) begin
          cmd_o.set_ovf = 1'b1;
          state_d = ST_RESULT;
        end else begin
          cmd_o.p2_init = 1'b1;
          state_d = ST_P2_RD;
        end
      end
      ST_P2_RD: begin
        priority if (!sts_i.cnt_ge_col) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ftins_pkg::RA_CNT;
          state_d = ST_P2_WR;
        end else if (sts_i.kind_fill) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ftins_pkg::RA_COL;
          state_d = ST_FILL_WR;
        end else begin
          cmd_o.sh_init = 1'b1;
          state_d = ST_SH_RD;
        end
      end
      ST_P2_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_data = ftins_pkg::WD_SECOND;
        cmd_o.p2_step = 1'b1;
        state_d = ST_P2_RD;
      end
      ST_FILL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_data = ftins_pkg::WD_FILL;
        state_d = ST_RESULT;
      end
      ST_SH_RD: begin
        if (sts_i.cnt_eq_col) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_data  = ftins_pkg::WD_NEW;
          cmd_o.inc_used = 1'b1;
          state_d = ST_RESULT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ftins_pkg::RA_CNT_M1;
          state_d = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_data = ftins_pkg::WD_SHIFT;
        cmd_o.sh_step = 1'b1;
        state_d = ST_SH_RD;
      end
      ST_READ: state_d = ST_RESULT;
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/ftins_datapath.sv
// Datapath of the Fibonacci tableau insert unit: column memory, walk
// registers, column count and result register. Depends on ftins_pkg.
`default_nettype none

module ftins_datapath #(
  parameter int MAX_COLUMNS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ftins_pkg::cmd_t    cmd_i,
  output ftins_pkg::status_t      sts_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         key_i,
  input  wire logic [7:0]         element_i,
  input  wire logic [5:0]         start_column_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [6:0]              column_count_o,
  output logic                    overflow_o,
  output logic [5:0]              settled_column_o,
  output logic [7:0]              read_top_o,
  output logic [7:0]              read_second_o,
  output logic [7:0]              read_key_top_o,
  output logic [7:0]              read_key_second_o
);

  localparam int AW  = $clog2(MAX_COLUMNS);
  localparam int UW  = $clog2(MAX_COLUMNS + 1);
  localparam int CW  = (UW > 6) ? UW : 6;
  localparam logic [UW-1:0] MaxCols = UW'(MAX_COLUMNS);

  ftins_pkg::column_t mem [MAX_COLUMNS];
  ftins_pkg::column_t rd_q;
  ftins_pkg::column_t wr_data;

  ftins_pkg::op_e op_q;
  logic [7:0]    key_q, elem_q, val_q;
  logic [5:0]    start_q;
  logic [CW-1:0] col_q, cnt_q;
  logic          fill_q, ovf_q;
  logic [UW-1:0] used_q;
  logic          out_valid_q;

  logic [CW-1:0] used_x, start_x, rd_full, wr_full;
  logic          out_free, read_hit;

  assign used_x   = CW'(used_q);
  assign start_x  = CW'(start_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign read_hit = (op_q == ftins_pkg::OP_READ) && (start_x < used_x);

  always_comb begin
    unique case (cmd_i.rd_addr)
      ftins_pkg::RA_COL:    rd_full = col_q;
      ftins_pkg::RA_CNT:    rd_full = cnt_q;
      ftins_pkg::RA_CNT_M1: rd_full = cnt_q - 1'b1;
      default:              rd_full = start_x;
    endcase
  end

  always_comb begin
    wr_full = col_q;
    wr_data = rd_q;
    unique case (cmd_i.wr_data)
      ftins_pkg::WD_SECOND: begin
        wr_full = cnt_q;
        wr_data = '{vt: rd_q.vt, vs: val_q, kt: rd_q.kt, ks: rd_q.ks};
      end
      ftins_pkg::WD_FILL: begin
        wr_data = '{vt: rd_q.vt, vs: val_q, kt: rd_q.kt, ks: key_q};
      end
      ftins_pkg::WD_SHIFT: begin
        wr_full = cnt_q;
        wr_data = rd_q;
      end
      default: begin
        wr_data = '{vt: val_q, vs: 8'd0, kt: key_q, ks: 8'd0};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_full[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_full[AW-1:0]];
    end
  end

  always_comb begin
    sts_o.op          = op_q;
    sts_o.past_end    = (col_q >= used_x);
    sts_o.val_lt_top  = (val_q < rd_q.vt);
    sts_o.second_zero = (rd_q.vs == 8'd0);
    sts_o.full_ovf    = !fill_q && (used_q == MaxCols);
    sts_o.cnt_ge_col  = (cnt_q >= col_q);
    sts_o.cnt_eq_col  = (cnt_q == col_q);
    sts_o.kind_fill   = fill_q;
    sts_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= ftins_pkg::op_e'(op_i);
      key_q   <= key_i;
      elem_q  <= element_i;
      start_q <= start_column_i;
      col_q   <= CW'(start_column_i);
      val_q   <= element_i;
      ovf_q   <= 1'b0;
    end
    if (cmd_i.walk_step) begin
      val_q <= rd_q.vs;
      col_q <= col_q + 1'b1;
    end
    if (cmd_i.set_fill) begin
      fill_q <= 1'b1;
    end
    if (cmd_i.set_insert) begin
      fill_q <= 1'b0;
    end
    if (cmd_i.set_append) begin
      fill_q <= 1'b0;
      col_q  <= used_x;
    end
    if (cmd_i.set_ovf) begin
      ovf_q <= 1'b1;
    end
    if (cmd_i.p2_init) begin
      cnt_q <= start_x;
      val_q <= elem_q;
    end
    if (cmd_i.p2_step) begin
      val_q <= rd_q.vs;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.sh_init) begin
      cnt_q <= used_x;
    end
    if (cmd_i.sh_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.load_out) begin
      column_count_o    <= 7'(used_q);
      overflow_o        <= (op_q == ftins_pkg::OP_INSERT) && ovf_q;
      settled_column_o  <= (op_q == ftins_pkg::OP_INSERT) ? col_q[5:0] : 6'd0;
      read_top_o        <= read_hit ? rd_q.vt : 8'd0;
      read_second_o     <= read_hit ? rd_q.vs : 8'd0;
      read_key_top_o    <= read_hit ? rd_q.kt : 8'd0;
      read_key_second_o <= read_hit ? rd_q.ks : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_used) begin
        used_q <= '0;
      end else if (cmd_i.inc_used) begin
        used_q <= used_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= MaxCols) else $error("column count above capacity");
  a_inc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.inc_used |-> used_q < MaxCols) else $error("column added to full tableau");
  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> !cmd_i.rd_en) else $error("read and write in one cycle");
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> wr_full <= used_x) else $error("write past used columns");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> out_free) else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for fibonacci_tableau_insert_unit: directed table, a fill to capacity, then random transactions.
// Checks every result against a behavioral tableau model, or typed table rows against the table; depends on ftins_pkg.
`timescale 1ns / 100ps
`default_nettype none

module tb;

  localparam int NCOL = 64;
  localparam int WATCHDOG = 20000;
  localparam int NRAND = 830;

  typedef struct packed {
    logic [6:0] cnt;
    logic       ovf;
    logic [5:0] settled;
    logic [7:0] rt;
    logic [7:0] rs;
    logic [7:0] rkt;
    logic [7:0] rks;
  } tab_result_t;

  typedef struct {
    ftins_pkg::op_e op;
    logic [7:0] key;
    logic [7:0] elem;
    logic [5:0] col;
    bit         typed;
    tab_result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] op_i = '0;
  logic [7:0] key_i = '0;
  logic [7:0] element_i = '0;
  logic [5:0] start_column_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, overflow_o;
  logic [6:0] column_count_o;
  logic [5:0] settled_column_o;
  logic [7:0] read_top_o, read_second_o, read_key_top_o, read_key_second_o;

  fibonacci_tableau_insert_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [7:0] m_vt [NCOL];
  logic [7:0] m_vs [NCOL];
  logic [7:0] m_kt [NCOL];
  logic [7:0] m_ks [NCOL];
  int unsigned m_used;

  tab_result_t pending_q[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_ovf = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  function automatic void tableau_clear();
    for (int i = 0; i < NCOL; i++) begin
      m_vt[i] = '0; m_vs[i] = '0; m_kt[i] = '0; m_ks[i] = '0;
    end
    m_used = 0;
  endfunction

  function automatic tab_result_t tableau_apply(ftins_pkg::op_e op, logic [7:0] key,
                                                logic [7:0] elem, logic [5:0] sc);
    tab_result_t r;
    int unsigned c, start;
    logic [7:0] v, t;
    bit fill;
    r = '0;
    start = sc;
    if (op == ftins_pkg::OP_INSERT) begin
      c = start;
      v = elem;
      fill = 0;
      forever begin
        if (c >= m_used) begin
          c = m_used;
          break;
        end
        if (v < m_vt[c]) begin
          if (m_vs[c] == 0) begin
            fill = 1;
            break;
          end
          v = m_vs[c];
          c++;
        end else break;
      end
      r.settled = c[5:0];
      if (!fill && m_used >= NCOL) r.ovf = 1'b1;
      else begin
        v = elem;
        for (int unsigned i = start; i < c; i++) begin
          t = m_vs[i]; m_vs[i] = v; v = t;
        end
        if (fill) begin
          m_vs[c] = v; m_ks[c] = key;
        end else begin
          for (int unsigned i = m_used; i > c; i--) begin
            m_vt[i] = m_vt[i-1]; m_vs[i] = m_vs[i-1];
            m_kt[i] = m_kt[i-1]; m_ks[i] = m_ks[i-1];
          end
          m_vt[c] = v; m_vs[c] = '0; m_kt[c] = key; m_ks[c] = '0;
          m_used++;
        end
      end
    end else if (op == ftins_pkg::OP_READ) begin
      if (start < m_used) begin
        r.rt = m_vt[start]; r.rs = m_vs[start];
        r.rkt = m_kt[start]; r.rks = m_ks[start];
      end
    end else if (op == ftins_pkg::OP_CLEAR) tableau_clear();
    r.cnt = m_used[6:0];
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(ftins_pkg::op_e op, logic [7:0] key, logic [7:0] elem,
                      logic [5:0] col, bit typed, tab_result_t res);
    tab_result_t pred;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op; key_i <= key; element_i <= elem; start_column_i <= col;
    do @(posedge clk_i); while (!in_ready_o);
    pred = tableau_apply(op, key, elem, col);
    if (typed && pred !== res)
      $display("%0t: table row mismatch expected %h model %h", $time, res, pred);
    pending_q = {pending_q, (typed ? res : pred)};
    n_sent++;
  endtask

  task automatic send_rand(ftins_pkg::op_e op, logic [5:0] col);
    logic [7:0] e;
    e = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) :
        8'($urandom_range(1, 255));
    send(op, 8'($urandom_range(0, 255)), e, col, 0, '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 3) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(10, 40);
    end else begin
      out_ready_i <= ($urandom_range(0, 99) < 70);
    end
  end

  always @(posedge clk_i) begin
    tab_result_t got, exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{column_count_o, overflow_o, settled_column_o, read_top_o, read_second_o,
              read_key_top_o, read_key_second_o};
      n_got++;
      if (overflow_o) n_ovf++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result actual %h", $time, got);
        errors++;
      end else begin
        exp = pending_q.pop_front();
        if (got.cnt !== exp.cnt)
          $display("%0t: column_count expected %0d actual %0d", $time, exp.cnt, got.cnt);
        if (got.ovf !== exp.ovf)
          $display("%0t: overflow expected %0d actual %0d", $time, exp.ovf, got.ovf);
        if (got.settled !== exp.settled)
          $display("%0t: settled expected %0d actual %0d", $time, exp.settled, got.settled);
        if (got.rt !== exp.rt)
          $display("%0t: read_top expected %h actual %h", $time, exp.rt, got.rt);
        if (got.rs !== exp.rs)
          $display("%0t: read_second expected %h actual %h", $time, exp.rs, got.rs);
        if (got.rkt !== exp.rkt)
          $display("%0t: read_key_top expected %h actual %h", $time, exp.rkt, got.rkt);
        if (got.rks !== exp.rks)
          $display("%0t: read_key_second expected %h actual %h", $time, exp.rks, got.rks);
        if (got !== exp) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  stim_row_t table_rows[$];

  function automatic void row(ftins_pkg::op_e op, logic [7:0] k, logic [7:0] e,
                              logic [5:0] c, bit typed, tab_result_t res);
    stim_row_t s;
    s.op = op; s.key = k; s.elem = e; s.col = c; s.typed = typed; s.res = res;
    table_rows = {table_rows, s};
  endfunction

  initial begin
    int p;
    tableau_clear();
    row(ftins_pkg::OP_READ, 8'h00, 8'h00, 6'd0, 1, '0);
    row(ftins_pkg::OP_NOP, 8'hff, 8'hff, 6'd63, 1, '0);
    row(ftins_pkg::OP_INSERT, 8'h01, 8'h80, 6'd63, 1,
        '{7'd1, 1'b0, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    row(ftins_pkg::OP_INSERT, 8'h02, 8'h40, 6'd0, 0, '0);
    row(ftins_pkg::OP_INSERT, 8'h03, 8'h20, 6'd0, 0, '0);
    row(ftins_pkg::OP_INSERT, 8'h04, 8'hff, 6'd0, 0, '0);
    row(ftins_pkg::OP_INSERT, 8'hff, 8'h01, 6'd1, 0, '0);
    row(ftins_pkg::OP_INSERT, 8'h05, 8'h00, 6'd2, 0, '0);
    row(ftins_pkg::OP_INSERT, 8'h06, 8'h10, 6'd0, 0, '0);
    row(ftins_pkg::OP_READ, 8'h00, 8'h00, 6'd0, 0, '0);
    row(ftins_pkg::OP_READ, 8'h00, 8'h00, 6'd1, 0, '0);
    row(ftins_pkg::OP_READ, 8'h00, 8'h00, 6'd2, 0, '0);
    row(ftins_pkg::OP_READ, 8'h00, 8'h00, 6'd63, 0, '0);
    row(ftins_pkg::OP_NOP, 8'h00, 8'h00, 6'd0, 0, '0);
    row(ftins_pkg::OP_CLEAR, 8'haa, 8'h55, 6'd21, 1, '0);
    row(ftins_pkg::OP_READ, 8'h00, 8'h00, 6'd0, 1, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i])
      send(table_rows[i].op, table_rows[i].key, table_rows[i].elem, table_rows[i].col,
           table_rows[i].typed, table_rows[i].res);
    wait_drained();

    // fill to capacity with equal tops, then hit overflow
    for (int i = 0; i < NCOL + 6; i++)
      send(ftins_pkg::OP_INSERT, 8'($urandom_range(0, 255)), 8'hff, 6'd63, 0, '0);
    for (int i = 0; i < 20; i++)
      send_rand(ftins_pkg::OP_INSERT, 6'($urandom_range(0, 63)));
    for (int i = 0; i < 10; i++)
      send_rand(ftins_pkg::OP_READ, 6'($urandom_range(0, 63)));
    wait_drained();
    send(ftins_pkg::OP_CLEAR, 8'h00, 8'h00, 6'd0, 1, '0);

    for (int i = 0; i < NRAND; i++) begin
      p = $urandom_range(0, 99);
      if (p < 70)
        send_rand(ftins_pkg::OP_INSERT,
                  6'($urandom_range(0, m_used > 0 ? m_used : 0) & 6'h3f));
      else if (p < 90) send_rand(ftins_pkg::OP_READ, 6'($urandom_range(0, 63)));
      else if (p < 93) send_rand(ftins_pkg::OP_CLEAR, 6'($urandom_range(0, 63)));
      else if (p < 96) send_rand(ftins_pkg::OP_NOP, 6'($urandom_range(0, 63)));
      else send_rand(ftins_pkg::OP_INSERT, 6'($urandom_range(0, 63)));
      if (i == NRAND / 2) wait_drained();
    end

    wait_drained();
    repeat (400) @(posedge clk_i);
    $display("Sent %0d transactions, got %0d results (%0d overflows), %0d errors.",
             n_sent, n_got, n_ovf, errors);
    $display("Covered inserts with fill, displace, open and append, reads, clears, no-ops.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
